>>> rtl/setup_frame_utf8_checker_assert.svh
// assertion macros for the setup frame checker
`ifndef SETUP_FRAME_UTF8_CHECKER_ASSERT_SVH
`define SETUP_FRAME_UTF8_CHECKER_ASSERT_SVH

`ifndef SYNTHESIS
// checked property, disabled while reset is high
`define SFU_CHECK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("setup frame checker assertion failed");
// checked property, also evaluated during reset
`define SFU_CHECK_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("setup frame checker assertion failed");
`else
`define SFU_CHECK(label, prop)
`define SFU_CHECK_ALWAYS(label, prop)
`endif

`endif

>>> rtl/sfu_pkg.sv
// shared types and constants of the setup frame checker
`timescale 1ns / 1ps

package sfu_pkg;

  localparam int NAME_CAPACITY_DEF = 32;

  localparam int POS_W = 9;
  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [POS_W-1:0] POS_NAME = POS_W'(7);
  localparam logic [POS_W-1:0] POS_PIN_LAST = POS_W'(6);

  localparam logic [7:0] VERSION_BYTE = 8'h01;
  localparam logic [7:0] HOP_MAX = 8'h07;

  localparam logic [31:0] PIN_NONE = 32'hffff_ffff;
  localparam logic [31:0] PIN_KEEP = 32'hffff_fffe;
  localparam logic [31:0] PIN_LIMIT = 32'd999999;

  localparam logic [7:0] CTRL_LOW = 8'h20;
  localparam logic [7:0] CTRL_DEL = 8'h7f;
  localparam logic [7:0] ASCII_END = 8'h80;
  localparam logic [20:0] CODE_MAX = 21'h10ffff;
  localparam logic [20:0] SURR_LO = 21'h00d800;
  localparam logic [20:0] SURR_HI = 21'h00dfff;
  localparam logic [20:0] MIN_TWO = 21'h000080;
  localparam logic [20:0] MIN_THREE = 21'h000800;
  localparam logic [20:0] MIN_FOUR = 21'h010000;

  localparam logic [1:0] CLASS_TWO = 2'd0;
  localparam logic [1:0] CLASS_THREE = 2'd1;
  localparam logic [1:0] CLASS_FOUR = 2'd2;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_VERDICT,
    ST_NAMES
  } sfu_state_t;

  typedef struct packed {
    logic take_byte;
    logic emit_header;
    logic emit_name;
    logic clear_frame;
  } sfu_cmd_t;

  typedef struct packed {
    logic ok;
    logic out_free;
    logic name_last;
  } sfu_status_t;

endpackage

>>> rtl/sfu_ctrl.sv
// sequencer of the setup frame checker: collect, verdict, name burst
`timescale 1ns / 1ps

module sfu_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               frame_valid,
  input  logic               frame_end,
  output logic               frame_stall,
  input  sfu_pkg::sfu_status_t status,
  output sfu_pkg::sfu_cmd_t    cmd
);
  import sfu_pkg::*;

  sfu_state_t state;
  sfu_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_COLLECT: begin
        if (frame_valid && frame_end) state_next = ST_VERDICT;
      end
      ST_VERDICT: begin
        if (status.out_free) state_next = status.ok ? ST_NAMES : ST_COLLECT;
      end
      ST_NAMES: begin
        if (status.out_free && status.name_last) state_next = ST_COLLECT;
      end
      default: begin
        state_next = ST_COLLECT;
      end
    endcase
  end

  always_comb begin
    frame_stall = 1'b1;
    cmd = '0;
    case (state)
      ST_COLLECT: begin
        frame_stall = 1'b0;
        cmd.take_byte = frame_valid;
      end
      ST_VERDICT: begin
        cmd.emit_header = status.out_free;
        cmd.clear_frame = status.out_free && !status.ok;
      end
      ST_NAMES: begin
        cmd.emit_name = status.out_free;
        cmd.clear_frame = status.out_free && status.name_last;
      end
      default: begin
        frame_stall = 1'b1;
      end
    endcase
  end

endmodule

>>> rtl/sfu_datapath.sv
// frame parser, utf-8 checker, name buffer and result register
`timescale 1ns / 1ps

module sfu_datapath #(
  parameter int NAME_CAPACITY = sfu_pkg::NAME_CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  sfu_pkg::sfu_cmd_t   cmd,
  output sfu_pkg::sfu_status_t status,
  input  logic [7:0]          frame_byte,
  input  logic                cfg_write,
  input  logic signed [31:0]  current_pin,
  output logic                result_valid,
  input  logic                result_stall,
  output logic                is_header,
  output logic                accepted,
  output logic [2:0]          hop_limit,
  output logic signed [20:0]  pin_value,
  output logic [4:0]          name_length,
  output logic [7:0]          name_byte,
  output logic                run_last
);
  import sfu_pkg::*;

  localparam int DEPTH = NAME_CAPACITY - 1;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [8:0] CAP9 = 9'(NAME_CAPACITY);
  localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(DEPTH);

  // frame state
  logic [POS_W-1:0] position, position_next;
  logic [2:0]  hop_reg, hop_reg_next;
  logic [7:0]  length_reg, length_reg_next;
  logic [31:0] pin_accum, pin_accum_next;
  logic [1:0]  tail_left, tail_left_next;
  logic [20:0] code_accum, code_accum_next;
  logic [1:0]  minimum_class, minimum_class_next;
  logic        fault_flag, fault_flag_next;

  logic signed [31:0] pin_reg;
  logic [7:0]  name_store [DEPTH];
  logic [7:0]  rd_data;
  logic [7:0]  name_idx;
  logic [20:0] pin_hold;

  logic [POS_W-1:0] store_idx;
  logic [1:0]  lane;
  logic        store_we;
  logic [20:0] code_shift;
  logic [20:0] code_min;

  logic        frame_ok, pin_ok, cur_ok, pin_none, pin_keep;
  logic [20:0] pin_sel;
  logic        rd_en;
  logic [7:0]  rd_idx;

  assign store_idx = position - POS_NAME;
  assign lane = 2'(position - POS_W'(3));
  assign code_shift = {code_accum[14:0], frame_byte[5:0]};
  assign store_we = cmd.take_byte && (position >= POS_NAME)
                    && (store_idx < {1'b0, length_reg}) && (store_idx < DEPTH_POS);

  always_comb begin
    case (minimum_class)
      CLASS_TWO:   code_min = MIN_TWO;
      CLASS_THREE: code_min = MIN_THREE;
      default:     code_min = MIN_FOUR;
    endcase
  end

  // one frame byte per transfer
  always_comb begin
    position_next = position;
    hop_reg_next = hop_reg;
    length_reg_next = length_reg;
    pin_accum_next = pin_accum;
    tail_left_next = tail_left;
    code_accum_next = code_accum;
    minimum_class_next = minimum_class;
    fault_flag_next = fault_flag;
    if (cmd.take_byte) begin
      if (position == POS_W'(0)) begin
        if (frame_byte != VERSION_BYTE) fault_flag_next = 1'b1;
      end else if (position == POS_W'(1)) begin
        if (frame_byte > HOP_MAX) fault_flag_next = 1'b1;
        hop_reg_next = frame_byte[2:0];
      end else if (position == POS_W'(2)) begin
        length_reg_next = frame_byte;
        if (frame_byte == 8'd0 || {1'b0, frame_byte} >= CAP9) fault_flag_next = 1'b1;
      end else if (position <= POS_PIN_LAST) begin
        case (lane)
          2'd0:    pin_accum_next[7:0]   = pin_accum[7:0] | frame_byte;
          2'd1:    pin_accum_next[15:8]  = pin_accum[15:8] | frame_byte;
          2'd2:    pin_accum_next[23:16] = pin_accum[23:16] | frame_byte;
          default: pin_accum_next[31:24] = pin_accum[31:24] | frame_byte;
        endcase
      end else if (store_idx >= {1'b0, length_reg}) begin
        fault_flag_next = 1'b1;
      end else if (tail_left == 2'd0) begin
        // lead byte
        if (frame_byte < CTRL_LOW || frame_byte == CTRL_DEL) begin
          fault_flag_next = 1'b1;
        end else if (frame_byte < ASCII_END) begin
          fault_flag_next = fault_flag;
        end else if (frame_byte inside {[8'hc2:8'hdf]}) begin
          tail_left_next = 2'd1;
          code_accum_next = {16'd0, frame_byte[4:0]};
          minimum_class_next = CLASS_TWO;
        end else if (frame_byte inside {[8'he0:8'hef]}) begin
          tail_left_next = 2'd2;
          code_accum_next = {17'd0, frame_byte[3:0]};
          minimum_class_next = CLASS_THREE;
        end else if (frame_byte inside {[8'hf0:8'hf4]}) begin
          tail_left_next = 2'd3;
          code_accum_next = {18'd0, frame_byte[2:0]};
          minimum_class_next = CLASS_FOUR;
        end else begin
          fault_flag_next = 1'b1;
        end
      end else if (frame_byte[7:6] != 2'b10) begin
        fault_flag_next = 1'b1;
        tail_left_next = 2'd0;
      end else begin
        code_accum_next = code_shift;
        tail_left_next = tail_left - 2'd1;
        if (tail_left == 2'd1) begin
          if (code_shift < code_min || code_shift > CODE_MAX
              || (code_shift >= SURR_LO && code_shift <= SURR_HI)) begin
            fault_flag_next = 1'b1;
          end
        end
      end
      if (position != POS_MAX) position_next = position + POS_W'(1);
    end
    if (cmd.clear_frame) begin
      position_next = '0;
      hop_reg_next = '0;
      length_reg_next = '0;
      pin_accum_next = '0;
      tail_left_next = '0;
      code_accum_next = '0;
      minimum_class_next = '0;
      fault_flag_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      hop_reg <= '0;
      length_reg <= '0;
      pin_accum <= '0;
      tail_left <= '0;
      code_accum <= '0;
      minimum_class <= '0;
      fault_flag <= 1'b0;
    end else begin
      position <= position_next;
      hop_reg <= hop_reg_next;
      length_reg <= length_reg_next;
      pin_accum <= pin_accum_next;
      tail_left <= tail_left_next;
      code_accum <= code_accum_next;
      minimum_class <= minimum_class_next;
      fault_flag <= fault_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_reg <= -32'sd1;
    end else if (cfg_write) begin
      pin_reg <= current_pin;
    end
  end

  // verdict from the settled frame state
  assign frame_ok = !fault_flag && (tail_left == 2'd0)
                    && (position == POS_NAME + POS_W'(length_reg))
                    && (position > POS_NAME);
  assign pin_none = (pin_accum == PIN_NONE);
  assign pin_keep = (pin_accum == PIN_KEEP);
  assign cur_ok = (pin_reg >= -32'sd1) && (pin_reg <= $signed(PIN_LIMIT));
  assign pin_ok = pin_none || (pin_keep ? cur_ok : (pin_accum <= PIN_LIMIT));
  assign pin_sel = pin_none ? '1 : (pin_keep ? pin_reg[20:0] : pin_accum[20:0]);

  assign status.ok = frame_ok && pin_ok;
  assign status.out_free = !result_valid || !result_stall;
  assign status.name_last = ({1'b0, name_idx} + 9'd1) == {1'b0, length_reg};

  // name buffer
  assign rd_idx = cmd.emit_header ? 8'd0 : (name_idx + 8'd1);
  assign rd_en = (cmd.emit_header && status.ok) || (cmd.emit_name && !status.name_last);

  always_ff @(posedge clk) begin
    if (store_we) name_store[store_idx[ADDR_W-1:0]] <= frame_byte;
    if (rd_en) rd_data <= name_store[rd_idx[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      name_idx <= '0;
    end else if (cmd.emit_header) begin
      name_idx <= '0;
    end else if (cmd.emit_name) begin
      name_idx <= name_idx + 8'd1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit_header || cmd.emit_name) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_header) begin
      is_header <= 1'b1;
      accepted <= status.ok;
      hop_limit <= status.ok ? hop_reg : 3'd0;
      pin_value <= status.ok ? $signed(pin_sel) : 21'sd0;
      name_length <= status.ok ? length_reg[4:0] : 5'd0;
      name_byte <= 8'd0;
      run_last <= !status.ok;
      pin_hold <= pin_sel;
    end else if (cmd.emit_name) begin
      is_header <= 1'b0;
      accepted <= 1'b1;
      hop_limit <= hop_reg;
      pin_value <= $signed(pin_hold);
      name_length <= length_reg[4:0];
      name_byte <= rd_data;
      run_last <= status.name_last;
    end
  end

endmodule

>>> rtl/setup_frame_utf8_checker.sv
// top level of the setup frame checker with utf-8 name validation
//
//  channel   direction  handshake                  payload
//  frame     in         frame_valid / frame_stall  frame_byte, frame_end
//  result    out        result_valid / result_stall is_header .. run_last
//  config    in         cfg_valid / cfg_ready      current_pin
//
// frame bytes are taken one per cycle while a frame is collected
// after the byte marked frame_end the frame input stalls until the results are out:
//   on an accepted frame with n name bytes the header in the verdict state, then one per name,
//   on a rejected one the header alone, and longer while the result side holds result_stall
// names come back from a one-write, one-read buffer, read one entry per result transfer
// rst is synchronous; it clears all frame state and sets the pin register to -1
// config writes are taken in any cycle (cfg_ready is tied high)
`timescale 1ns / 1ps

module setup_frame_utf8_checker #(
  parameter int NAME_CAPACITY = sfu_pkg::NAME_CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // frame bytes
  input  logic               frame_valid,
  output logic               frame_stall,
  input  logic [7:0]         frame_byte,
  input  logic               frame_end,
  // results
  output logic               result_valid,
  input  logic               result_stall,
  output logic               is_header,
  output logic               accepted,
  output logic [2:0]         hop_limit,
  output logic signed [20:0] pin_value,
  output logic [4:0]         name_length,
  output logic [7:0]         name_byte,
  output logic               run_last,
  // register write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [31:0] current_pin
);
  import sfu_pkg::*;

`include "setup_frame_utf8_checker_assert.svh"

  sfu_cmd_t    cmd;
  sfu_status_t status;

  // register port never backs up
  assign cfg_ready = 1'b1;

  sfu_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_end   (frame_end),
    .frame_stall (frame_stall),
    .status      (status),
    .cmd         (cmd)
  );

  sfu_datapath #(
    .NAME_CAPACITY (NAME_CAPACITY)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .frame_byte   (frame_byte),
    .cfg_write    (cfg_valid && cfg_ready),
    .current_pin  (current_pin),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .is_header    (is_header),
    .accepted     (accepted),
    .hop_limit    (hop_limit),
    .pin_value    (pin_value),
    .name_length  (name_length),
    .name_byte    (name_byte),
    .run_last     (run_last)
  );

  // the byte that closes a frame always stalls the next transfer for the verdict
  `SFU_CHECK(a_end_stalls, frame_valid && !frame_stall && frame_end |=> frame_stall)
  // a rejected frame yields a single header that closes the frame
  `SFU_CHECK(a_reject_last, result_valid && is_header && !accepted |-> run_last)
  // name bytes only follow an accepted header
  `SFU_CHECK(a_name_accepted, result_valid && !is_header |-> accepted)
  // results are only produced while frame input is held off
  `SFU_CHECK(a_new_result_stalled, $rose(result_valid) |-> $past(frame_stall))

endmodule

>>> test/tb_setup_frame_utf8_checker.sv
// self-checking testbench for the setup frame checker with utf-8 name validation
`timescale 1ns / 1ps

module tb_setup_frame_utf8_checker;
  import sfu_pkg::*;

  localparam int NAME_CAP = NAME_CAPACITY_DEF;
  localparam int STORE_DEPTH = NAME_CAP - 1;
  // wait after a frame end that covers the longest result burst, plus margin
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS = 230;
  localparam int PHASE_ITEMS = 30;
  localparam int PIN_PHASES = 7;

  // one result transfer, field by field
  typedef struct packed {
    logic        is_header;
    logic        accepted;
    logic [2:0]  hop_limit;
    logic [20:0] pin_value;
    logic [4:0]  name_length;
    logic [7:0]  name_byte;
    logic        run_last;
  } frame_result_t;

  // the only result of a rejected frame
  localparam frame_result_t REJECT_HEADER = '{is_header: 1'b1, accepted: 1'b0,
    hop_limit: 3'd0, pin_value: 21'd0, name_length: 5'd0, name_byte: 8'd0,
    run_last: 1'b1};

  // directed row: one frame byte, and a typed header where the verdict is obvious
  typedef struct packed {
    logic [7:0]    value;
    logic          end_flag;
    logic          typed;
    frame_result_t header;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 30;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // wrong version, frame of a single byte
    '{8'hff, 1'b1, 1'b1, REJECT_HEADER},
    // hop at its top, no pin, one ascii name byte
    '{8'h01, 1'b0, 1'b0, '0}, '{8'h07, 1'b0, 1'b0, '0}, '{8'h01, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0}, '{8'hff, 1'b0, 1'b0, '0}, '{8'hff, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0}, '{8'h7e, 1'b1, 1'b0, '0},
    // frame ends inside the pin field
    '{8'h01, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0}, '{8'h01, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b1, REJECT_HEADER},
    // keep the pin in force, two-byte char at the lowest legal code point
    '{8'h01, 1'b0, 1'b0, '0}, '{8'h03, 1'b0, 1'b0, '0}, '{8'h02, 1'b0, 1'b0, '0},
    '{8'hfe, 1'b0, 1'b0, '0}, '{8'hff, 1'b0, 1'b0, '0}, '{8'hff, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0}, '{8'hc2, 1'b0, 1'b0, '0}, '{8'h80, 1'b1, 1'b0, '0},
    // pin zero, control byte as the name
    '{8'h01, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0}, '{8'h01, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b1, 1'b1, REJECT_HEADER}
  };

  // pin register settings of the random phases, the last one is drawn at run time
  localparam logic [31:0] PHASE_PINS [PIN_PHASES-1] = '{
    32'd0, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff, PIN_KEEP, PIN_LIMIT + 32'd1
  };

  logic               clk;
  logic               rst;
  logic               frame_valid;
  logic               frame_stall;
  logic [7:0]         frame_byte;
  logic               frame_end;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic               is_header;
  logic               accepted;
  logic [2:0]         hop_limit;
  logic signed [20:0] pin_value;
  logic [4:0]         name_length;
  logic [7:0]         name_byte;
  logic               run_last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic signed [31:0] current_pin;

  // travels with each frame byte so the checker knows a typed header is due
  logic               row_typed;
  frame_result_t      row_header;

  // shadow of the block: pin register and per-frame parser state
  logic [31:0]   pin_in_force;
  logic [8:0]    frame_pos;
  logic [2:0]    hop_seen;
  logic [7:0]    length_seen;
  logic [31:0]   pin_code;
  logic [1:0]    utf8_tail;
  logic [20:0]   code_point;
  logic [1:0]    code_class;
  logic          frame_fault;
  logic [7:0]    name_copy [STORE_DEPTH];

  frame_result_t results_due [$];
  frame_result_t oldest_due;
  int            fail_count = 0;
  int            stall_left = 0;
  bit            quiet = 1'b0;

  // byte streams built by the frame generator
  logic [7:0]    pend_bytes [$];
  logic [7:0]    name_bytes [$];

  setup_frame_utf8_checker DUT (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame_byte   (frame_byte),
    .frame_end    (frame_end),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .is_header    (is_header),
    .accepted     (accepted),
    .hop_limit    (hop_limit),
    .pin_value    (pin_value),
    .name_length  (name_length),
    .name_byte    (name_byte),
    .run_last     (run_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .current_pin  (current_pin)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // walk one accepted frame byte through the frame parser and the utf-8 checker,
  // queue the verdict and the name bytes on the last byte
  task automatic predict_frame_byte(input logic [7:0] b, input logic last_byte,
                                    input logic typed, input frame_result_t typed_header);
    int unsigned   p;
    int unsigned   idx;
    int unsigned   k;
    logic [20:0]   floor_cp;
    logic          verdict;
    logic [31:0]   pin_out;
    frame_result_t r;
    p = frame_pos;
    if (p == 0) begin
      if (b != VERSION_BYTE) frame_fault = 1'b1;
    end else if (p == 1) begin
      if (b > HOP_MAX) frame_fault = 1'b1;
      hop_seen = b[2:0];
    end else if (p == 2) begin
      length_seen = b;
      if (b == 8'd0 || b >= NAME_CAP) frame_fault = 1'b1;
    end else if (p <= 6) begin
      // little-endian pin code
      pin_code = pin_code | ({24'd0, b} << (8 * (p - 3)));
    end else begin
      idx = p - 7;
      if (idx >= length_seen) begin
        // byte past the announced name length
        frame_fault = 1'b1;
      end else begin
        if (idx < STORE_DEPTH) name_copy[idx] = b;
        if (utf8_tail == 2'd0) begin
          // lead byte or plain ascii
          if (b < CTRL_LOW || b == CTRL_DEL) begin
            frame_fault = 1'b1;
          end else if (b >= ASCII_END) begin
            if (b >= 8'hc2 && b <= 8'hdf) begin
              utf8_tail = 2'd1;
              code_point = {16'd0, b[4:0]};
              code_class = CLASS_TWO;
            end else if (b >= 8'he0 && b <= 8'hef) begin
              utf8_tail = 2'd2;
              code_point = {17'd0, b[3:0]};
              code_class = CLASS_THREE;
            end else if (b >= 8'hf0 && b <= 8'hf4) begin
              utf8_tail = 2'd3;
              code_point = {18'd0, b[2:0]};
              code_class = CLASS_FOUR;
            end else begin
              // stray continuation, c0/c1 or f5 and up
              frame_fault = 1'b1;
            end
          end
        end else if (b[7:6] != 2'b10) begin
          // sequence broken off by a non-continuation byte
          frame_fault = 1'b1;
          utf8_tail = 2'd0;
        end else begin
          code_point = {code_point[14:0], b[5:0]};
          utf8_tail = utf8_tail - 2'd1;
          if (utf8_tail == 2'd0) begin
            floor_cp = (code_class == CLASS_TWO) ? MIN_TWO :
                       (code_class == CLASS_THREE) ? MIN_THREE : MIN_FOUR;
            // overlong, beyond u+10ffff, or surrogate
            if (code_point < floor_cp || code_point > CODE_MAX ||
                (code_point >= SURR_LO && code_point <= SURR_HI))
              frame_fault = 1'b1;
          end
        end
      end
    end
    // position saturates, long frames are rejected anyway
    if (frame_pos != POS_MAX) frame_pos = frame_pos + 9'd1;
    if (!last_byte) return;

    // truncated sequence and wrong frame length both reject
    verdict = !frame_fault && int'(frame_pos) == 7 + int'(length_seen) &&
              utf8_tail == 2'd0 && p >= 7;
    pin_out = 32'd0;
    if (verdict) begin
      if (pin_code == PIN_NONE) begin
        pin_out = PIN_NONE;
      end else if (pin_code == PIN_KEEP) begin
        // kept pin must itself be a legal value
        if ($signed(pin_in_force) < -1 || $signed(pin_in_force) > $signed(PIN_LIMIT))
          verdict = 1'b0;
        else
          pin_out = pin_in_force;
      end else if (pin_code <= PIN_LIMIT) begin
        pin_out = pin_code;
      end else begin
        verdict = 1'b0;
      end
    end

    if (typed) begin
      results_due.push_back(typed_header);
    end else if (!verdict) begin
      results_due.push_back(REJECT_HEADER);
    end else begin
      r = '{is_header: 1'b1, accepted: 1'b1, hop_limit: hop_seen,
            pin_value: pin_out[20:0], name_length: length_seen[4:0],
            name_byte: 8'd0, run_last: 1'b0};
      results_due.push_back(r);
      for (k = 0; k < length_seen && k < STORE_DEPTH; k++) begin
        r.is_header = 1'b0;
        r.name_byte = name_copy[k];
        r.run_last = (k + 1 == length_seen);
        results_due.push_back(r);
      end
    end

    // everything but the name store and the pin register starts over
    frame_pos = '0;
    hop_seen = '0;
    length_seen = '0;
    pin_code = '0;
    utf8_tail = '0;
    code_point = '0;
    code_class = '0;
    frame_fault = 1'b0;
  endtask

  // prediction and checking on the same edge, so the order between processes
  // never matters
  always @(posedge clk) begin
    if (rst) begin
      pin_in_force = 32'hffff_ffff;
      frame_pos = '0;
      hop_seen = '0;
      length_seen = '0;
      pin_code = '0;
      utf8_tail = '0;
      code_point = '0;
      code_class = '0;
      frame_fault = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) pin_in_force = current_pin;
      if (frame_valid && !frame_stall)
        predict_frame_byte(frame_byte, frame_end, row_typed, row_header);
      if (result_valid && !result_stall) begin
        if (results_due.size() == 0) begin
          $error("result transfer with nothing expected: is_header %0d name_byte %0h",
                 is_header, name_byte);
          fail_count++;
        end else begin
          oldest_due = results_due.pop_front();
          if (is_header !== oldest_due.is_header) begin
            $error("is_header: expected %0h, actual %0h", oldest_due.is_header, is_header);
            fail_count++;
          end
          if (accepted !== oldest_due.accepted) begin
            $error("accepted: expected %0h, actual %0h", oldest_due.accepted, accepted);
            fail_count++;
          end
          if (hop_limit !== oldest_due.hop_limit) begin
            $error("hop_limit: expected %0h, actual %0h", oldest_due.hop_limit, hop_limit);
            fail_count++;
          end
          if (pin_value !== oldest_due.pin_value) begin
            $error("pin_value: expected %0d, actual %0d",
                   $signed(oldest_due.pin_value), pin_value);
            fail_count++;
          end
          if (name_length !== oldest_due.name_length) begin
            $error("name_length: expected %0h, actual %0h",
                   oldest_due.name_length, name_length);
            fail_count++;
          end
          if (name_byte !== oldest_due.name_byte) begin
            $error("name_byte: expected %0h, actual %0h", oldest_due.name_byte, name_byte);
            fail_count++;
          end
          if (run_last !== oldest_due.run_last) begin
            $error("run_last: expected %0h, actual %0h", oldest_due.run_last, run_last);
            fail_count++;
          end
        end
      end
    end
  end

  // result side holds off in random bursts, never in the quiet phase
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 7);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // one frame byte transfer, after an optional idle burst
  task automatic send_byte(input logic [7:0] v, input logic last_byte,
                           input logic typed, input frame_result_t hdr);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      frame_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    frame_valid <= 1'b1;
    frame_byte <= v;
    frame_end <= last_byte;
    row_typed <= typed;
    row_header <= hdr;
    @(posedge clk);
    while (frame_stall) @(posedge clk);
  endtask

  // pin register write, only once the block has drained
  task automatic write_pin(input logic [31:0] v);
    frame_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    current_pin <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // append one code point encoded in nb bytes, nb may be too many (overlong)
  task automatic push_code(input logic [20:0] cp, input int unsigned nb);
    case (nb)
      1: name_bytes.push_back(cp[7:0]);
      2: begin
        name_bytes.push_back({3'b110, cp[10:6]});
        name_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        name_bytes.push_back({4'b1110, cp[15:12]});
        name_bytes.push_back({2'b10, cp[11:6]});
        name_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        name_bytes.push_back({5'b11110, cp[20:18]});
        name_bytes.push_back({2'b10, cp[17:12]});
        name_bytes.push_back({2'b10, cp[11:6]});
        name_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // build the next random frame into pend_bytes: mostly well-formed frames with
  // random names, some with one utf-8 fault, bad fields, wrong length, or noise
  task automatic make_frame();
    int unsigned want;
    int unsigned room;
    int unsigned nb;
    int unsigned pick;
    int unsigned kind;
    bit          faulty;
    bit          boundary;
    logic [20:0] cp;
    logic [31:0] pin;
    logic [7:0]  len_field;
    pend_bytes.delete();
    name_bytes.delete();

    // plain noise, any bytes, end on the last one
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 12)) pend_bytes.push_back(8'($urandom));
      return;
    end

    // mostly short names, now and then the full store
    pick = $urandom_range(0, 19);
    want = (pick == 0) ? STORE_DEPTH :
           (pick < 3) ? $urandom_range(9, STORE_DEPTH - 1) : $urandom_range(1, 8);
    faulty = ($urandom_range(0, 3) == 0);

    while (name_bytes.size() < want) begin
      room = want - name_bytes.size();
      if (faulty && $urandom_range(0, 4) == 0) begin
        kind = $urandom_range(0, 8);
        if (kind == 0)
          // control byte or delete
          push_code(($urandom_range(0, 1) != 0) ? 21'(CTRL_DEL) : 21'($urandom_range(0, 31)), 1);
        else if (kind == 1)
          // continuation byte with no lead
          push_code(21'($urandom_range(8'h80, 8'hbf)), 1);
        else if (kind == 2)
          // lead byte that is never legal
          push_code(21'($urandom_range(8'hf5, 8'hff)), 1);
        else if (kind == 3 && room >= 2)
          // overlong two-byte form, c0/c1 lead
          push_code(21'($urandom_range(0, 8'h7f)), 2);
        else if (kind == 4 && room >= 3)
          push_code(21'($urandom_range(0, 12'h7ff)), 3);
        else if (kind == 5 && room >= 3)
          // utf-16 surrogate
          push_code(21'($urandom_range(SURR_LO, SURR_HI)), 3);
        else if (kind == 6 && room >= 4)
          push_code(21'($urandom_range(0, 16'hffff)), 4);
        else if (kind == 7 && room >= 4)
          // above u+10ffff
          push_code(21'($urandom_range(21'h110000, 21'h1fffff)), 4);
        else
          // lone lead: broken by the next byte or truncated at the end
          push_code(21'($urandom_range(8'hc2, 8'hf4)), 1);
      end else begin
        nb = $urandom_range(1, (room < 4) ? room : 4);
        boundary = ($urandom_range(0, 3) == 0);
        case (nb)
          1: cp = boundary ? (($urandom_range(0, 1) != 0) ? 21'h7e : 21'h20) :
                             21'($urandom_range(8'h20, 8'h7e));
          2: cp = boundary ? (($urandom_range(0, 1) != 0) ? 21'h7ff : 21'h80) :
                             21'($urandom_range(8'h80, 12'h7ff));
          3: begin
            if (boundary) begin
              case ($urandom_range(0, 3))
                0: cp = 21'h000800;
                1: cp = 21'h00d7ff;
                2: cp = 21'h00e000;
                default: cp = 21'h00ffff;
              endcase
            end else begin
              cp = 21'($urandom_range(12'h800, 16'hffff));
              if (cp >= SURR_LO && cp <= SURR_HI) cp = cp ^ 21'h001000;
            end
          end
          default: cp = boundary ? (($urandom_range(0, 1) != 0) ? CODE_MAX : MIN_FOUR) :
                                   21'($urandom_range(MIN_FOUR, CODE_MAX));
        endcase
        push_code(cp, nb);
      end
    end

    case ($urandom_range(0, 19))
      0: len_field = 8'd0;
      1: len_field = 8'($urandom_range(NAME_CAP, 255));
      2: len_field = 8'(name_bytes.size() + 1);
      3: len_field = 8'(name_bytes.size() - 1);
      default: len_field = 8'(name_bytes.size());
    endcase

    case ($urandom_range(0, 7))
      0, 1: pin = PIN_NONE;
      2: pin = PIN_KEEP;
      3: pin = PIN_LIMIT;
      4: pin = PIN_LIMIT + 32'd1;
      5: pin = $urandom;
      default: pin = $urandom_range(0, 999999);
    endcase

    pend_bytes.push_back(($urandom_range(0, 24) == 0) ? 8'($urandom) : VERSION_BYTE);
    pend_bytes.push_back(($urandom_range(0, 14) == 0) ? 8'($urandom_range(8, 255)) :
                                                        8'($urandom_range(0, 7)));
    pend_bytes.push_back(len_field);
    pend_bytes.push_back(pin[7:0]);
    pend_bytes.push_back(pin[15:8]);
    pend_bytes.push_back(pin[23:16]);
    pend_bytes.push_back(pin[31:24]);
    foreach (name_bytes[i]) pend_bytes.push_back(name_bytes[i]);

    // frame ended early, or with bytes past the name
    if ($urandom_range(0, 14) == 0)
      repeat ($urandom_range(1, pend_bytes.size() - 1)) void'(pend_bytes.pop_back());
    else if ($urandom_range(0, 14) == 0)
      repeat ($urandom_range(1, 4)) pend_bytes.push_back(8'($urandom));
  endtask

  initial begin
    int ph;
    int k;
    int random_items;
    int item_goal;
    rst <= 1'b1;
    frame_valid <= 1'b0;
    frame_byte <= 8'd0;
    frame_end <= 1'b0;
    row_typed <= 1'b0;
    row_header <= '0;
    cfg_valid <= 1'b0;
    current_pin <= 32'sd0;
    random_items = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed frames run with the pin register at its upper legal value
    write_pin(PIN_LIMIT);
    for (k = 0; k < DIRECTED_ROWS; k++)
      send_byte(directed_rows[k].value, directed_rows[k].end_flag,
                directed_rows[k].typed, directed_rows[k].header);

    // random frames, a new pin setting per phase, the last phase without idling
    for (ph = 0; ph < PIN_PHASES; ph++) begin
      quiet = (ph == PIN_PHASES - 1);
      write_pin((ph == PIN_PHASES - 1) ? 32'($urandom_range(0, 999999)) : PHASE_PINS[ph]);
      item_goal = quiet ? RANDOM_ITEMS : (ph + 1) * PHASE_ITEMS;
      while (random_items < item_goal) begin
        make_frame();
        for (k = 0; k < pend_bytes.size(); k++)
          send_byte(pend_bytes[k], k == pend_bytes.size() - 1, 1'b0, '0);
        random_items += pend_bytes.size();
      end
    end

    // drain, then let the block settle before the verdict
    frame_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
